// ----- src/tpfr_pkg.sv -----
// ----------------------------------------------------------------------------
// tpfr_pkg
// Shared types, register indexes and constants of the touch panel frame
// receiver.
// ----------------------------------------------------------------------------
package tpfr_pkg;

   localparam int BYTE_W         = 8;
   localparam int DIGIT_W        = 3;
   localparam int NUM_DIGITS     = 5;
   localparam int CSR_IDX_W      = 3;
   localparam int SEQ_LENGTH_DEF = 5;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_BYTE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_REPORT_BASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRE_PAGE        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQUENCE_COMMAND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQUENCE_ENABLE  = 3'd5;

   // ASCII offset and bounds of a sequence digit
   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_ONE  = 8'h31;
   localparam logic [BYTE_W-1:0] ASCII_FIVE = 8'h35;

   typedef enum logic [3:0] {
      PH_HEAD1 = 4'b0001,
      PH_HEAD2 = 4'b0010,
      PH_CMD   = 4'b0100,
      PH_SEQ   = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_PAGE = 2'd1,
      EV_CMD  = 2'd2,
      EV_SEQ  = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_byte;
      logic [BYTE_W-1:0] tail_byte;
      logic [BYTE_W-1:0] page_report_base;
      logic [BYTE_W-1:0] fire_page;
      logic [BYTE_W-1:0] sequence_command;
      logic              sequence_enable;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              line_error;
   } item_type;

   typedef struct packed {
      event_kind_type                      event_kind;
      logic [BYTE_W-1:0]                   current_page;
      logic                                refresh_fire;
      logic [BYTE_W-1:0]                   command_byte;
      logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;
   } result_type;

   // Handshake status between the input and output registers
   typedef struct packed {
      logic advance;
   } flow_type;

endpackage

// ----- src/tpfr_if.sv -----
// ----------------------------------------------------------------------------
// tpfr_req_if / tpfr_rsp_if
// Valid/ready channels for received bytes and for receiver events.
// ----------------------------------------------------------------------------
interface tpfr_req_if;
   logic                      valid;
   logic                      ready;
   logic [tpfr_pkg::BYTE_W-1:0] rx_byte;
   logic                      line_error;

   modport source (output valid, output rx_byte, output line_error, input ready);
   modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

interface tpfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   event_kind;
   logic [tpfr_pkg::BYTE_W-1:0]  current_page;
   logic                         refresh_fire;
   logic [tpfr_pkg::BYTE_W-1:0]  command_byte;
   logic [tpfr_pkg::DIGIT_W-1:0] digit_one;
   logic [tpfr_pkg::DIGIT_W-1:0] digit_two;
   logic [tpfr_pkg::DIGIT_W-1:0] digit_three;
   logic [tpfr_pkg::DIGIT_W-1:0] digit_four;
   logic [tpfr_pkg::DIGIT_W-1:0] digit_five;

   modport source (output valid, output event_kind, output current_page,
                   output refresh_fire, output command_byte, output digit_one,
                   output digit_two, output digit_three, output digit_four,
                   output digit_five, input ready);
   modport sink   (input valid, input event_kind, input current_page,
                   input refresh_fire, input command_byte, input digit_one,
                   input digit_two, input digit_three, input digit_four,
                   input digit_five, output ready);
endinterface

// ----- src/tpfr_csr.sv -----
// ----------------------------------------------------------------------------
// tpfr_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module tpfr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [tpfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpfr_pkg::BYTE_W-1:0]    csr_wdata,
   output tpfr_pkg::cfg_type              cfg
);
   import tpfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HEADER_BYTE:      cfg_in.header_byte      = csr_wdata;
            CSR_TAIL_BYTE:        cfg_in.tail_byte        = csr_wdata;
            CSR_PAGE_REPORT_BASE: cfg_in.page_report_base = csr_wdata;
            CSR_FIRE_PAGE:        cfg_in.fire_page        = csr_wdata;
            CSR_SEQUENCE_COMMAND: cfg_in.sequence_command = csr_wdata;
            CSR_SEQUENCE_ENABLE:  cfg_in.sequence_enable  = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{header_byte:      '0,
                     tail_byte:        8'hFF,
                     page_report_base: '0,
                     fire_page:        '0,
                     sequence_command: '0,
                     sequence_enable:  1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/tpfr_in_stage.sv -----
// ----------------------------------------------------------------------------
// tpfr_in_stage
// Input register with the valid/ready flow control of the pipeline.
// ----------------------------------------------------------------------------
module tpfr_in_stage (
   input  logic               clock,
   input  logic               reset,
   tpfr_req_if.sink           req,
   input  logic               out_free,
   output tpfr_pkg::flow_type flow,
   output tpfr_pkg::item_type item
);
   import tpfr_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     advance;
   logic     take;

   // Item moves on when the result register can take it
   assign advance   = valid_ff & out_free;
   assign req.ready = ~valid_ff | advance;
   assign take      = req.valid & req.ready;
   assign valid_in  = take | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, loaded on each transfer
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.rx_byte    <= req.rx_byte;
         item_ff.line_error <= req.line_error;
      end
   end

   assign flow.advance  = advance;
   assign item          = item_ff;

endmodule

// ----- src/tpfr_frame_core.sv -----
// ----------------------------------------------------------------------------
// tpfr_frame_core
// Frame state machine: header hunt, command decode, sequence collection.
// ----------------------------------------------------------------------------
module tpfr_frame_core #(
   parameter int SEQ_LENGTH = tpfr_pkg::SEQ_LENGTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tpfr_pkg::flow_type   flow,
   input  tpfr_pkg::item_type   item,
   input  tpfr_pkg::cfg_type    cfg,
   output tpfr_pkg::result_type result
);
   import tpfr_pkg::*;

   localparam int CNT_W = $clog2(SEQ_LENGTH + 1);

   phase_type                       phase_ff, phase_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [BYTE_W-1:0]               page_ff, page_in;
   logic [SEQ_LENGTH-1:0][BYTE_W-1:0] store_ff;
   logic                            store_wr;
   logic [SEQ_LENGTH-1:0]           digit_ok;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0] seq_digits;
   logic [BYTE_W-1:0]               page_off;
   logic                            in_page_range;
   logic                            seq_full;

   // Per-entry digit check and conversion
   for (genvar g = 0; g < SEQ_LENGTH; g++) begin : g_check
      assign digit_ok[g] = (store_ff[g] >= ASCII_ONE) && (store_ff[g] <= ASCII_FIVE);
   end

   for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_digit
      if (g < SEQ_LENGTH) begin : g_used
         logic [BYTE_W-1:0] diff;
         assign diff          = store_ff[g] - ASCII_ZERO;
         assign seq_digits[g] = diff[DIGIT_W-1:0];
      end else begin : g_unused
         assign seq_digits[g] = '0;
      end
   end

   assign page_off      = item.rx_byte - cfg.page_report_base;
   assign in_page_range = (item.rx_byte >= cfg.page_report_base) &&
                          (page_off <= cfg.fire_page);
   assign seq_full      = (count_ff == CNT_W'(SEQ_LENGTH));

   // Next state and result for the item in the input register
   always_comb begin
      phase_in              = phase_ff;
      count_in              = count_ff;
      page_in               = page_ff;
      store_wr              = 1'b0;
      result.event_kind     = EV_NONE;
      result.refresh_fire   = 1'b0;
      result.command_byte   = '0;
      result.digits         = '0;
      if (item.line_error) begin
         phase_in = PH_HEAD1;
         count_in = '0;
      end else begin
         case (phase_ff)
            PH_HEAD1: begin
               if (item.rx_byte == cfg.header_byte) begin
                  phase_in = PH_HEAD2;
               end
            end
            PH_HEAD2: begin
               phase_in = (item.rx_byte == cfg.header_byte) ? PH_CMD : PH_HEAD1;
            end
            PH_CMD: begin
               if (in_page_range) begin
                  page_in             = page_off;
                  result.event_kind   = EV_PAGE;
                  result.refresh_fire = (page_off == cfg.fire_page);
                  phase_in            = PH_HEAD1;
               end else if (item.rx_byte == cfg.sequence_command) begin
                  count_in = '0;
                  phase_in = PH_SEQ;
               end else begin
                  result.event_kind   = EV_CMD;
                  result.command_byte = item.rx_byte;
                  phase_in            = PH_HEAD1;
               end
            end
            PH_SEQ: begin
               if (item.rx_byte == cfg.tail_byte) begin
                  if (seq_full && cfg.sequence_enable && (&digit_ok)) begin
                     result.event_kind = EV_SEQ;
                     result.digits     = seq_digits;
                  end
                  phase_in = PH_HEAD1;
               end else if (!seq_full) begin
                  store_wr = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  // overlong sequence aborts the frame
                  phase_in = PH_HEAD1;
               end
            end
            default: begin
               phase_in = PH_HEAD1;
            end
         endcase
      end
      result.current_page = page_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD1;
         count_ff <= '0;
         page_ff  <= '0;
      end else if (flow.advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         page_ff  <= page_in;
      end
   end

   // Sequence byte store, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < SEQ_LENGTH; i++) begin
         if (flow.advance && store_wr && (count_ff == CNT_W'(i))) begin
            store_ff[i] <= item.rx_byte;
         end
      end
   end

endmodule

// ----- src/tpfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// tpfr_out_stage
// Result register driving the event channel.
// ----------------------------------------------------------------------------
module tpfr_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  tpfr_pkg::flow_type   flow,
   input  tpfr_pkg::result_type result,
   output logic                 out_free,
   tpfr_rsp_if.source           rsp
);
   import tpfr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // Free when empty or when the held result is taken this cycle
   assign out_free = ~valid_ff | rsp.ready;
   assign valid_in = flow.advance | (valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.advance) begin
         result_ff <= result;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.event_kind   = result_ff.event_kind;
   assign rsp.current_page = result_ff.current_page;
   assign rsp.refresh_fire = result_ff.refresh_fire;
   assign rsp.command_byte = result_ff.command_byte;
   assign rsp.digit_one    = result_ff.digits[0];
   assign rsp.digit_two    = result_ff.digits[1];
   assign rsp.digit_three  = result_ff.digits[2];
   assign rsp.digit_four   = result_ff.digits[3];
   assign rsp.digit_five   = result_ff.digits[4];

endmodule

// ----- src/touch_panel_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// touch_panel_frame_receiver_unit
// Display link frame receiver: header hunt, page reports, plain commands and
// five-digit sequence reports.
// ----------------------------------------------------------------------------
//  channel  direction  handshake      payload
//  req      in         valid/ready    rx_byte, line_error
//  rsp      out        valid/ready    event_kind, current_page, refresh_fire,
//                                     command_byte, digit_one..digit_five
//  csr      in         csr_wr_en      csr_index, csr_wdata
//
// One byte per cycle sustained while rsp is ready; each byte gives one result
// through the input register, then the result register.
// Synchronous reset clears phase, count, page and both valid flags; the
// sequence store is not reset.
// When rsp stalls, one result waits in the result register and one more
// byte is held in the input register before req.ready drops.
// ----------------------------------------------------------------------------
module touch_panel_frame_receiver_unit #(
   parameter int SEQ_LENGTH = tpfr_pkg::SEQ_LENGTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   tpfr_req_if.sink                       req,
   tpfr_rsp_if.source                     rsp,
   input  logic                           csr_wr_en,
   input  logic [tpfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpfr_pkg::BYTE_W-1:0]    csr_wdata
);
   import tpfr_pkg::*;

   cfg_type    cfg;
   flow_type   flow;
   item_type   item;
   result_type result;
   logic       out_free;

   tpfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpfr_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .out_free (out_free),
      .flow     (flow),
      .item     (item)
   );

   tpfr_frame_core #(
      .SEQ_LENGTH (SEQ_LENGTH)
   ) u_frame_core (
      .clock  (clock),
      .reset  (reset),
      .flow   (flow),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   tpfr_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .flow     (flow),
      .result   (result),
      .out_free (out_free),
      .rsp      (rsp)
   );

endmodule
